// File: hdl/humidity_temp_frame_decoder_core_assert.svh
// ============================================================================
// Assertion macros for the humidity/temperature frame decoder
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define HTFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define HTFD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define HTFD_ASSERT(label, clk, rst, prop)
`define HTFD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: hdl/htfd_pkg.sv
// ============================================================================
// Humidity/temperature frame decoder package
// Shared types, constants, CRC-8 and constant-divisor helper functions.
// ============================================================================
package htfd_pkg;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_MIN    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_MAX    = 2'd2;

   localparam logic [9:0]         TEMP_OFFSET_RESET = 10'd10;
   localparam logic signed [11:0] TEMP_MIN_RESET    = -12'sd400;
   localparam logic signed [11:0] TEMP_MAX_RESET    = 12'sd1250;

   localparam logic [2:0] POS_TEMP_MSB = 3'd0;
   localparam logic [2:0] POS_TEMP_LSB = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUM_MSB  = 3'd3;
   localparam logic [2:0] POS_HUM_LSB  = 3'd4;
   localparam logic [2:0] POS_HUM_CRC  = 3'd5;

   localparam int MAG_W = 27;
   localparam int QUO_W = 11;

   localparam logic signed [27:0] TEMP_GAIN = 28'sd1750;
   localparam logic signed [27:0] TEMP_BIAS = 28'sd29490750;
   localparam logic [25:0]        HUM_GAIN  = 26'd1000;
   localparam logic [27:0]        FULL_SCALE = 28'd65535;

   typedef struct packed {
      logic               ok;
      logic signed [16:0] diff;
      logic [15:0]        raw_h;
   } word_type;

   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Lower estimate of x / 65535, never more than one below the true quotient.
   function automatic logic [QUO_W-1:0] div_est(input logic [MAG_W-1:0] x);
      logic [MAG_W:0] sum;
      sum = {1'b0, x} + {{(MAG_W+1-QUO_W){1'b0}}, x[MAG_W-1:16]};
      return sum[MAG_W-1:16];
   endfunction

   function automatic logic [QUO_W-1:0] div_fix(input logic [MAG_W-1:0] x,
                                                input logic [QUO_W-1:0] q);
      logic [MAG_W:0] rem;
      rem = {1'b0, x} - {1'b0, q, 16'd0} + {{(MAG_W+1-QUO_W){1'b0}}, q};
      return (rem >= FULL_SCALE) ? q + QUO_W'(1) : q;
   endfunction

endpackage

// File: hdl/humidity_temp_frame_decoder_core.sv
// ============================================================================
// Humidity/temperature frame decoder core
// Decodes six-byte CRC-8 checked sensor frames into temperature and humidity
// in tenths, with a configurable raw offset and temperature clamp.
// ============================================================================
//
//   Port group   Direction   Transaction
//   req_*        in          one frame byte and its frame start flag
//   rsp_*        out         one decoded reading per complete frame
//   csr_*        in          register write, index and 12-bit data
//
// One byte is taken every cycle when the result side keeps up.
// After its last byte is accepted, a reading passes through one input
// register, one frame register and five scaling stages.
// Reset is synchronous and empties every stage; registers return to defaults.
// A stalled result holds its stage; the stages behind it keep filling and
// the input stalls only once the pipeline is full.
//
module humidity_temp_frame_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_frame_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [11:0]                rsp_temperature_tenths,
   output logic [9:0]                        rsp_humidity_tenths,
   output logic                              rsp_crc_error,
   input  logic                              csr_write,
   input  logic [htfd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [htfd_pkg::CSR_DATA_W-1:0]   csr_data
);

   logic [9:0]          temp_offset_ff;
   logic signed [11:0]  temp_min_ff;
   logic signed [11:0]  temp_max_ff;
   htfd_pkg::word_type  word;
   logic                word_valid;
   logic                word_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_offset_ff <= htfd_pkg::TEMP_OFFSET_RESET;
         temp_min_ff    <= htfd_pkg::TEMP_MIN_RESET;
         temp_max_ff    <= htfd_pkg::TEMP_MAX_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            htfd_pkg::CSR_TEMP_OFFSET: temp_offset_ff <= csr_data[9:0];
            htfd_pkg::CSR_TEMP_MIN:    temp_min_ff    <= $signed(csr_data);
            htfd_pkg::CSR_TEMP_MAX:    temp_max_ff    <= $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   htfd_frame u_frame (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_frame_start (req_frame_start),
      .temp_raw_offset (temp_offset_ff),
      .word            (word),
      .word_valid      (word_valid),
      .word_ready      (word_ready)
   );

   htfd_scale u_scale (
      .clock                  (clock),
      .reset                  (reset),
      .word                   (word),
      .word_valid             (word_valid),
      .word_ready             (word_ready),
      .temp_min               (temp_min_ff),
      .temp_max               (temp_max_ff),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .rsp_humidity_tenths    (rsp_humidity_tenths),
      .rsp_crc_error          (rsp_crc_error)
   );

endmodule

// File: hdl/htfd_frame.sv
// ============================================================================
// Frame tracker
// Registers incoming bytes, follows the frame position, checks both CRC-8
// bytes and hands the raw words of a complete frame to the scaler.
// ============================================================================
module htfd_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_frame_start,
   input  logic [9:0]          temp_raw_offset,
   output htfd_pkg::word_type  word,
   output logic                word_valid,
   input  logic                word_ready
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_start_ff;
   logic [2:0]          pos_ff, pos_in;
   logic [7:0]          held_ff [4];
   logic [7:0]          held_in [4];
   logic [7:0]          crc_ff, crc_in;
   logic                first_ok_ff, first_ok_in;
   logic                word_valid_ff, word_valid_in;
   htfd_pkg::word_type  word_ff, word_in;
   logic [2:0]          pos;
   logic                emit;
   logic                s1_ready;
   logic                s0_take;
   logic                in_ready;

   assign s1_ready  = !word_valid_ff || word_ready;
   assign s0_take   = in_valid_ff && (!emit || s1_ready);
   assign in_ready  = !in_valid_ff || s0_take;
   assign req_stall = !in_ready;
   assign in_valid_in = in_ready ? req_valid : in_valid_ff;

   always_comb begin
      pos = (in_start_ff || (pos_ff > htfd_pkg::POS_HUM_CRC)) ? htfd_pkg::POS_TEMP_MSB
                                                              : pos_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      first_ok_in = first_ok_ff;
      held_in     = held_ff;
      emit        = 1'b0;
      unique case (pos)
         htfd_pkg::POS_TEMP_LSB: begin
            held_in[1] = in_byte_ff;
            crc_in     = htfd_pkg::crc_byte(crc_ff, in_byte_ff);
            pos_in     = htfd_pkg::POS_TEMP_CRC;
         end
         htfd_pkg::POS_TEMP_CRC: begin
            first_ok_in = (crc_ff == in_byte_ff);
            crc_in      = htfd_pkg::CRC_INIT;
            pos_in      = htfd_pkg::POS_HUM_MSB;
         end
         htfd_pkg::POS_HUM_MSB: begin
            held_in[2] = in_byte_ff;
            crc_in     = htfd_pkg::crc_byte(htfd_pkg::CRC_INIT, in_byte_ff);
            pos_in     = htfd_pkg::POS_HUM_LSB;
         end
         htfd_pkg::POS_HUM_LSB: begin
            held_in[3] = in_byte_ff;
            crc_in     = htfd_pkg::crc_byte(crc_ff, in_byte_ff);
            pos_in     = htfd_pkg::POS_HUM_CRC;
         end
         htfd_pkg::POS_HUM_CRC: begin
            emit   = 1'b1;
            crc_in = htfd_pkg::CRC_INIT;
            pos_in = htfd_pkg::POS_TEMP_MSB;
         end
         default: begin
            held_in[0] = in_byte_ff;
            crc_in     = htfd_pkg::crc_byte(htfd_pkg::CRC_INIT, in_byte_ff);
            pos_in     = htfd_pkg::POS_TEMP_LSB;
         end
      endcase
   end

   always_comb begin
      word_in.ok    = first_ok_ff && (crc_ff == in_byte_ff);
      word_in.diff  = $signed({1'b0, held_ff[0], held_ff[1]})
                    - $signed({7'd0, temp_raw_offset});
      word_in.raw_h = {held_ff[2], held_ff[3]};
   end

   assign word_valid_in = (word_valid_ff && !word_ready) || (s0_take && emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pos_ff        <= htfd_pkg::POS_TEMP_MSB;
         crc_ff        <= htfd_pkg::CRC_INIT;
         first_ok_ff   <= 1'b0;
         word_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         word_valid_ff <= word_valid_in;
         if (s0_take) begin
            pos_ff      <= pos_in;
            crc_ff      <= crc_in;
            first_ok_ff <= first_ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
      end
      if (s0_take) begin
         held_ff <= held_in;
      end
      if (s0_take && emit) begin
         word_ff <= word_in;
      end
   end

   assign word       = word_ff;
   assign word_valid = word_valid_ff;

endmodule

// File: hdl/htfd_scale.sv
// ============================================================================
// Result scaler
// Five-stage pipeline: gain products, magnitude, quotient estimate, quotient
// correction with sign, then clamp or error zeroing into the result register.
// ============================================================================
`include "humidity_temp_frame_decoder_core_assert.svh"

module htfd_scale (
   input  logic                      clock,
   input  logic                      reset,
   input  htfd_pkg::word_type        word,
   input  logic                      word_valid,
   output logic                      word_ready,
   input  logic signed [11:0]        temp_min,
   input  logic signed [11:0]        temp_max,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [11:0]        rsp_temperature_tenths,
   output logic [9:0]                rsp_humidity_tenths,
   output logic                      rsp_crc_error
);

   localparam int NSTAGE = 5;

   logic [NSTAGE-1:0] v_ff, v_in;
   logic [NSTAGE-1:0] rdy;
   logic [NSTAGE-1:0] v_prev;

   logic signed [27:0]           a_num_ff, a_num_in;
   logic [25:0]                  a_hp_ff, a_hp_in;
   logic                         a_ok_ff;

   logic [htfd_pkg::MAG_W-1:0]   b_tmag_ff, b_tmag_in;
   logic                         b_neg_ff;
   logic [25:0]                  b_hp_ff;
   logic                         b_ok_ff;

   logic [htfd_pkg::MAG_W-1:0]   c_tmag_ff, c_hmag_ff, c_hmag_in;
   logic [htfd_pkg::QUO_W-1:0]   c_tq_ff, c_tq_in, c_hq_ff, c_hq_in;
   logic                         c_neg_ff;
   logic                         c_ok_ff;

   logic signed [11:0]           d_t_ff, d_t_in;
   logic [9:0]                   d_h_ff, d_h_in;
   logic                         d_ok_ff;
   logic [htfd_pkg::QUO_W-1:0]   d_tq, d_hq;

   logic signed [11:0]           e_t_ff, e_t_in;
   logic [9:0]                   e_h_ff, e_h_in;
   logic                         e_err_ff;

   logic                         rsp_good;
   logic                         rsp_zero;
   logic                         temp_in_range;
   logic [23:0]                  limits;

   assign v_prev = {v_ff[NSTAGE-2:0], word_valid};

   always_comb begin
      rdy[NSTAGE-1] = !v_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
      for (int k = 0; k < NSTAGE; k++) begin
         v_in[k] = rdy[k] ? v_prev[k] : v_ff[k];
      end
   end

   assign word_ready = rdy[0];

   always_comb begin
      a_num_in = $signed({{11{word.diff[16]}}, word.diff}) * htfd_pkg::TEMP_GAIN
               - htfd_pkg::TEMP_BIAS;
      a_hp_in  = {10'd0, word.raw_h} * htfd_pkg::HUM_GAIN;

      b_tmag_in = a_num_ff[27] ? htfd_pkg::MAG_W'(-a_num_ff)
                               : a_num_ff[htfd_pkg::MAG_W-1:0];

      c_hmag_in = {1'b0, b_hp_ff};
      c_tq_in   = htfd_pkg::div_est(b_tmag_ff);
      c_hq_in   = htfd_pkg::div_est(c_hmag_in);

      d_tq   = htfd_pkg::div_fix(c_tmag_ff, c_tq_ff);
      d_hq   = htfd_pkg::div_fix(c_hmag_ff, c_hq_ff);
      d_t_in = c_neg_ff ? -$signed({1'b0, d_tq}) : $signed({1'b0, d_tq});
      d_h_in = d_hq[9:0];

      if (!d_ok_ff) begin
         e_t_in = '0;
         e_h_in = '0;
      end else begin
         e_h_in = d_h_ff;
         if (d_t_ff > temp_max) begin
            e_t_in = temp_max;
         end else if (d_t_ff < temp_min) begin
            e_t_in = temp_min;
         end else begin
            e_t_in = d_t_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         a_num_ff <= a_num_in;
         a_hp_ff  <= a_hp_in;
         a_ok_ff  <= word.ok;
      end
      if (rdy[1]) begin
         b_tmag_ff <= b_tmag_in;
         b_neg_ff  <= a_num_ff[27];
         b_hp_ff   <= a_hp_ff;
         b_ok_ff   <= a_ok_ff;
      end
      if (rdy[2]) begin
         c_tmag_ff <= b_tmag_ff;
         c_hmag_ff <= c_hmag_in;
         c_tq_ff   <= c_tq_in;
         c_hq_ff   <= c_hq_in;
         c_neg_ff  <= b_neg_ff;
         c_ok_ff   <= b_ok_ff;
      end
      if (rdy[3]) begin
         d_t_ff  <= d_t_in;
         d_h_ff  <= d_h_in;
         d_ok_ff <= c_ok_ff;
      end
      if (rdy[4]) begin
         e_t_ff   <= e_t_in;
         e_h_ff   <= e_h_in;
         e_err_ff <= !d_ok_ff;
      end
   end

   assign rsp_valid              = v_ff[NSTAGE-1];
   assign rsp_temperature_tenths = e_t_ff;
   assign rsp_humidity_tenths    = e_h_ff;
   assign rsp_crc_error          = e_err_ff;

   assign rsp_good      = rsp_valid && !rsp_crc_error;
   assign rsp_zero      = (rsp_temperature_tenths == 12'sd0) && (rsp_humidity_tenths == 10'd0);
   assign limits        = {temp_min, temp_max};
   assign temp_in_range = (temp_min > temp_max)
                       || ((rsp_temperature_tenths >= temp_min)
                           && (rsp_temperature_tenths <= temp_max));

   `HTFD_ASSERT(a_error_zeroes, clock, reset, (rsp_valid && rsp_crc_error) |-> rsp_zero)
   `HTFD_ASSERT(a_humidity_range, clock, reset, rsp_good |-> (rsp_humidity_tenths <= 10'd1000))
   `HTFD_ASSERT(a_temp_clamped, clock, reset, (rsp_good && $stable(limits)) |-> temp_in_range)
   `HTFD_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (v_ff == '0))

endmodule
